@@ src/gbn_pkg.sv @@
// gbn_pkg: shared types, codes and helpers of the go-back-n connection engine
// no dependencies; imported by every module of the block but gbn_ram
`timescale 1ns / 1ps

package gbn_pkg;

  // default sizes, the top level hands these down as parameters
  localparam int unsigned WINDOW_DEF = 16;
  localparam int unsigned SEND_QUEUE_DEPTH_DEF = 16;

  // widest slot index and burst length over the supported window range
  localparam int unsigned SLOT_MAX_W = 6;
  localparam int unsigned CNT_MAX_W = 7;

  localparam int unsigned PLAN_FIFO_DEPTH = 2;

  // register indexes
  localparam logic CFG_RETX = 1'b0;
  localparam logic CFG_TWAIT = 1'b1;

  localparam logic [31:0] RETX_TICKS_RST = 32'd1000;
  localparam logic [31:0] TWAIT_TICKS_RST = 32'd30000;

  // actions
  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_SEG = 3'd1;
  localparam logic [2:0] ACT_CONNECT = 3'd2;
  localparam logic [2:0] ACT_ACCEPT = 3'd3;
  localparam logic [2:0] ACT_PUSH = 3'd4;
  localparam logic [2:0] ACT_CLOSE = 3'd5;

  // segment flags
  localparam logic [2:0] F_ACK = 3'b100;
  localparam logic [2:0] F_SYN = 3'b010;
  localparam logic [2:0] F_FIN = 3'b001;
  localparam logic [2:0] F_NONE = 3'b000;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_TX = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;

  // connection states
  localparam logic [3:0] ST_CLOSED = 4'd0;
  localparam logic [3:0] ST_ESTABLISHED = 4'd1;
  localparam logic [3:0] ST_CLOSE_WAIT = 4'd2;
  localparam logic [3:0] ST_FIN_WAIT_1 = 4'd3;
  localparam logic [3:0] ST_FIN_WAIT_2 = 4'd4;
  localparam logic [3:0] ST_LAST_ACK = 4'd5;
  localparam logic [3:0] ST_TIME_WAIT = 4'd6;
  localparam logic [3:0] ST_SYN_SENT = 4'd7;
  localparam logic [3:0] ST_SYN_SEND = 4'd8;
  localparam logic [3:0] ST_SYN_ACK = 4'd9;
  localparam logic [3:0] ST_FIN_SEND = 4'd10;
  localparam logic [3:0] ST_SYN_RCVD = 4'd11;
  localparam logic [3:0] ST_IDLE = 4'd12;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] seg_seq;
    logic [2:0]  seg_flags;
    logic        checksum_ok;
    logic [7:0]  payload_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] tx_seq;
    logic [2:0]  tx_flags;
    logic [7:0]  out_handle;
    logic        has_payload;
    logic [3:0]  conn_state;
    logic        queue_full;
    logic        last;
  } out_item_t;

  // one sent segment as kept for retransmission
  typedef struct packed {
    logic [2:0] flags;
    logic       pl;
    logic [7:0] handle;
  } win_entry_t;

  localparam int unsigned WIN_ENTRY_W = $bits(win_entry_t);

  // everything one transaction asks the back end to emit, in emit order
  typedef struct packed {
    logic                  new_v;
    logic [31:0]           new_seq;
    logic [2:0]            new_flags;
    logic [7:0]            new_handle;
    logic                  new_pl;
    logic                  rt_v;
    logic [31:0]           rt_base;
    logic [SLOT_MAX_W-1:0] rt_slot;
    logic [CNT_MAX_W-1:0]  rt_cnt;
    logic                  rep_v;
    logic [31:0]           rep_seq;
    logic                  del_v;
    logic [7:0]            del_handle;
    logic                  ack_v;
    logic [31:0]           ack_seq;
    logic [2:0]            ack_flags;
    logic [3:0]            state;
    logic                  full;
  } plan_t;

  // a limit of zero counts as one
  function automatic logic [31:0] eff_limit(logic [31:0] v);
    return (v == 32'd0) ? 32'd1 : v;
  endfunction

endpackage

@@ src/go_back_n_connection_engine.sv @@
// go_back_n_connection_engine: top level of the go-back-n connection engine
// path from input transaction to its first result: accept, execute, plan
// pickup, output register; a new input is taken only after the last has
// executed, results go out at one per cycle while the output is not stalled,
// retransmitted segments each after a window read; input stalls while a burst
// is pending. reset is asynchronous active low: connection goes to idle,
// counters to 1, timers stopped, registers to their defaults; no clearing pass
// depends on gbn_pkg, gbn_ram, gbn_front, gbn_fifo, gbn_back
`timescale 1ns / 1ps

module go_back_n_connection_engine import gbn_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF,
  parameter int unsigned SEND_QUEUE_DEPTH = SEND_QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  localparam int unsigned SW = $clog2(WINDOW);

  // front to queue
  logic       plan_push, plan_room;
  plan_t      plan_in, plan_out;
  // queue to back
  logic       plan_valid, plan_pop;
  // window memory: front writes new segments, back reads bursts
  logic       win_we, win_re;
  logic [SW-1:0] win_waddr, win_raddr;
  win_entry_t win_wdata, win_rdata;
  logic [WIN_ENTRY_W-1:0] win_rdata_raw;
  // burst completion releases the input side
  logic       rt_done;

  gbn_front #(
    .WINDOW           (WINDOW),
    .SEND_QUEUE_DEPTH (SEND_QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .plan_push_o (plan_push),
    .plan_o      (plan_in),
    .plan_room_i (plan_room),
    .rt_done_i   (rt_done),
    .win_we_o    (win_we),
    .win_waddr_o (win_waddr),
    .win_wdata_o (win_wdata)
  );

  // sent segments, indexed by sequence number modulo the window
  gbn_ram #(
    .WIDTH (WIN_ENTRY_W),
    .DEPTH (WINDOW)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (win_wdata),
    .re_i    (win_re),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata_raw)
  );

  assign win_rdata = win_entry_t'(win_rdata_raw);

  gbn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (plan_push),
    .data_i  (plan_in),
    .room_o  (plan_room),
    .valid_o (plan_valid),
    .pop_i   (plan_pop),
    .data_o  (plan_out)
  );

  gbn_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (plan_valid),
    .plan_i       (plan_out),
    .plan_pop_o   (plan_pop),
    .win_re_o     (win_re),
    .win_raddr_o  (win_raddr),
    .win_rdata_i  (win_rdata),
    .rt_done_o    (rt_done),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ src/gbn_ram.sv @@
// gbn_ram: generic one-write one-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module gbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gbn_fifo.sv @@
// gbn_fifo: short plan queue between the front and the back end
// depends on gbn_pkg
`timescale 1ns / 1ps

module gbn_fifo import gbn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  plan_t data_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  pop_i,
  output plan_t data_o
);

  localparam int unsigned PW = $clog2(PLAN_FIFO_DEPTH);
  localparam int unsigned CW = $clog2(PLAN_FIFO_DEPTH + 1);

  plan_t         mem_q [PLAN_FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign room_o  = cnt_q != CW'(PLAN_FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && room_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(PLAN_FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(PLAN_FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ src/gbn_front.sv @@
// gbn_front: accepts transactions, keeps connection state and timers,
// builds one plan per transaction; depends on gbn_pkg and gbn_ram
`timescale 1ns / 1ps

module gbn_front import gbn_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF,
  parameter int unsigned SEND_QUEUE_DEPTH = SEND_QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  in_item_t                  in_data_i,
  output logic                      plan_push_o,
  output plan_t                     plan_o,
  input  logic                      plan_room_i,
  input  logic                      rt_done_i,
  output logic                      win_we_o,
  output logic [$clog2(WINDOW)-1:0] win_waddr_o,
  output win_entry_t                win_wdata_o
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam int unsigned QAW = $clog2(SEND_QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(SEND_QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FS_ACC  = 2'b01,
    FS_EXEC = 2'b10
  } front_state_e;

  front_state_e fstate_q, fstate_d;
  in_item_t     in_q;

  logic [31:0]  retx_lim_q, twait_lim_q;
  logic [3:0]   mode_q, mode_d;
  logic [31:0]  next_q, next_d, base_q, base_d, exp_q, exp_d;
  logic [SW-1:0] nslot_q, nslot_d, bslot_q, bslot_d;
  logic [QAW-1:0] head_q, head_d;
  logic [QCW-1:0] qcnt_q, qcnt_d;
  logic         rrun_q, rrun_d, crun_q, crun_d;
  logic [31:0]  rcnt_q, rcnt_d, ccnt_q, ccnt_d;
  logic [31:0]  aseq_q, aseq_d;
  logic [2:0]   aflg_q, aflg_d;
  logic         burst_q, burst_d;

  logic         accept, hs, send, want, sq_we, send_ok, in_order;
  logic [2:0]   sf;
  logic         spl;
  logic [7:0]   sh, pop_h, sq_rdata;
  logic [QCW:0] tail_sum;
  logic [QAW-1:0] tail;
  logic [31:0]  nb, d1, d2, outst;
  logic [SW+1:0] bsum;
  plan_t        plan;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (fstate_q == FS_ACC) && plan_room_i && !burst_q;
  assign hs         = (in_q.action == ACT_SEG) && in_q.checksum_ok;

  assign tail_sum = (QCW+1)'(head_q) + (QCW+1)'(qcnt_q);
  assign tail = (tail_sum >= (QCW+1)'(SEND_QUEUE_DEPTH)) ?
                QAW'(tail_sum - (QCW+1)'(SEND_QUEUE_DEPTH)) : QAW'(tail_sum);

  gbn_ram #(
    .WIDTH (8),
    .DEPTH (SEND_QUEUE_DEPTH)
  ) u_sq_ram (
    .clk_i   (clk_i),
    .we_i    (sq_we),
    .waddr_i (tail),
    .wdata_i (in_q.payload_handle),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (sq_rdata)
  );

  // a chunk pushed into an empty queue is taken from the input at once
  assign pop_h = (qcnt_q == '0) ? in_q.payload_handle : sq_rdata;

  always_comb begin
    mode_d  = mode_q;
    next_d  = next_q;
    base_d  = base_q;
    exp_d   = exp_q;
    nslot_d = nslot_q;
    bslot_d = bslot_q;
    head_d  = head_q;
    qcnt_d  = qcnt_q;
    rrun_d  = rrun_q;
    rcnt_d  = rcnt_q;
    crun_d  = crun_q;
    ccnt_d  = ccnt_q;
    aseq_d  = aseq_q;
    aflg_d  = aflg_q;
    burst_d = burst_q;
    fstate_d = fstate_q;
    plan    = '0;
    sq_we   = 1'b0;
    send    = 1'b0;
    want    = 1'b0;
    send_ok = 1'b0;
    in_order = 1'b0;
    sf      = F_NONE;
    spl     = 1'b0;
    sh      = '0;
    nb      = in_q.seg_seq + 32'd1;
    d1      = '0;
    d2      = '0;
    outst   = '0;
    bsum    = '0;
    win_we_o    = 1'b0;
    win_waddr_o = nslot_q;
    win_wdata_o = '0;
    plan_push_o = 1'b0;

    if (rt_done_i) begin
      burst_d = 1'b0;
    end

    case (fstate_q)
      FS_ACC: begin
        if (accept) begin
          fstate_d = FS_EXEC;
        end
      end
      FS_EXEC: begin
        fstate_d = FS_ACC;
        // timers tick first
        if (rrun_d && rcnt_d != '1) begin
          rcnt_d = rcnt_d + 32'd1;
        end
        if (crun_d && ccnt_d != '1) begin
          ccnt_d = ccnt_d + 32'd1;
        end

        case (in_q.action)
          ACT_CONNECT, ACT_ACCEPT: begin
            if (mode_d == ST_IDLE || mode_d == ST_CLOSED) begin
              next_d  = 32'd1;
              base_d  = 32'd1;
              exp_d   = 32'd1;
              nslot_d = SW'(1);
              bslot_d = SW'(1);
              head_d  = '0;
              qcnt_d  = '0;
              crun_d  = 1'b0;
              ccnt_d  = '0;
              aseq_d  = '0;
              aflg_d  = F_ACK;
              mode_d  = (in_q.action == ACT_CONNECT) ? ST_SYN_SEND : ST_SYN_ACK;
              rrun_d  = 1'b1;
              rcnt_d  = '0;
            end
          end
          ACT_PUSH: begin
            if (qcnt_d < QCW'(SEND_QUEUE_DEPTH)) begin
              sq_we  = 1'b1;
              qcnt_d = qcnt_d + 1'b1;
            end else begin
              plan.full = 1'b1;
            end
          end
          ACT_CLOSE: begin
            if (mode_d == ST_ESTABLISHED) begin
              mode_d = ST_FIN_SEND;
            end
          end
          default: ;
        endcase

        if (mode_d != ST_IDLE && mode_d != ST_CLOSED) begin
          // sender side
          if (mode_d == ST_TIME_WAIT) begin
            if (crun_d && ccnt_d >= eff_limit(twait_lim_q)) begin
              mode_d = ST_CLOSED;
              crun_d = 1'b0;
            end
          end else begin
            send_ok = (next_d - base_d) < 32'(WINDOW);
            want = (qcnt_d != '0) || mode_d == ST_SYN_SEND || mode_d == ST_SYN_SENT ||
                   mode_d == ST_FIN_SEND || mode_d == ST_FIN_WAIT_1 ||
                   mode_d == ST_FIN_WAIT_2 || mode_d == ST_CLOSE_WAIT;
            if (send_ok && want) begin
              case (mode_d)
                ST_SYN_SEND: begin
                  sf = F_SYN; send = 1'b1; mode_d = ST_SYN_SENT;
                end
                ST_SYN_SENT: begin
                  if (hs && in_q.seg_flags[2] && in_q.seg_flags[1]) begin
                    sf = F_ACK; send = 1'b1; mode_d = ST_ESTABLISHED;
                  end
                end
                ST_ESTABLISHED: begin
                  if (qcnt_d != '0) begin
                    sh     = pop_h;
                    head_d = (head_q == QAW'(SEND_QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
                    qcnt_d = qcnt_d - 1'b1;
                    spl    = 1'b1;
                    send   = 1'b1;
                  end
                end
                ST_FIN_SEND: begin
                  sf = F_FIN; send = 1'b1; mode_d = ST_FIN_WAIT_1;
                end
                ST_FIN_WAIT_1: begin
                  if (hs && in_q.seg_flags[2]) begin
                    mode_d = ST_FIN_WAIT_2;
                  end
                end
                ST_FIN_WAIT_2: begin
                  if (hs && in_q.seg_flags[0]) begin
                    sf = F_ACK; send = 1'b1; mode_d = ST_TIME_WAIT;
                    crun_d = 1'b1; ccnt_d = '0;
                  end
                end
                ST_CLOSE_WAIT: begin
                  sf = F_FIN; send = 1'b1; mode_d = ST_LAST_ACK;
                end
                default: ;
              endcase
              if (send) begin
                win_we_o        = 1'b1;
                win_waddr_o     = nslot_d;
                win_wdata_o     = '{flags: sf, pl: spl, handle: sh};
                plan.new_v      = 1'b1;
                plan.new_seq    = next_d;
                plan.new_flags  = sf;
                plan.new_handle = sh;
                plan.new_pl     = spl;
                if (base_d == next_d) begin
                  rrun_d = 1'b1; rcnt_d = '0;
                end
                nslot_d = (next_d == '1) ? '0 :
                          (nslot_d == SW'(WINDOW - 1)) ? '0 : nslot_d + 1'b1;
                next_d  = next_d + 32'd1;
              end
            end
          end

          // cumulative ack
          if (hs && in_q.seg_flags[2]) begin
            d1 = nb - base_d;
            d2 = next_d - base_d;
            if (d1 <= d2) begin
              bsum = (SW+2)'(bslot_d) + (SW+2)'(d1[SW:0]);
              bslot_d = (bsum >= (SW+2)'(WINDOW)) ? SW'(bsum - (SW+2)'(WINDOW)) : SW'(bsum);
              base_d = nb;
              rrun_d = (base_d != next_d);
              rcnt_d = '0;
            end
          end

          // retransmit timeout
          if (rrun_d && rcnt_d >= eff_limit(retx_lim_q)) begin
            rcnt_d = '0;
            outst = next_d - base_d;
            if (outst > 32'(WINDOW)) begin
              outst = 32'(WINDOW);
            end
            if (outst != '0) begin
              plan.rt_v    = 1'b1;
              plan.rt_base = base_d;
              plan.rt_slot = SLOT_MAX_W'(bslot_d);
              plan.rt_cnt  = CNT_MAX_W'(outst);
            end
          end

          // receiver side
          if (mode_d == ST_SYN_ACK) begin
            mode_d = ST_SYN_RCVD;
            aseq_d = exp_d;
            aflg_d = F_ACK | F_SYN;
            plan.rep_v   = 1'b1;
            plan.rep_seq = exp_d;
            exp_d = exp_d + 32'd1;
          end
          if (hs && !in_q.seg_flags[1] && mode_d != ST_CLOSE_WAIT) begin
            in_order = in_q.seg_seq == exp_d;
            if (in_order) begin
              plan.ack_v = 1'b1;
              if (mode_d == ST_SYN_RCVD && in_q.seg_flags[2]) begin
                plan.ack_v = 1'b0;
                mode_d = ST_ESTABLISHED;
              end else if (mode_d == ST_ESTABLISHED && in_q.seg_flags == F_NONE) begin
                plan.del_v      = 1'b1;
                plan.del_handle = in_q.payload_handle;
              end else if (mode_d == ST_ESTABLISHED && in_q.seg_flags[0]) begin
                mode_d = ST_CLOSE_WAIT;
              end else if (mode_d == ST_LAST_ACK && in_q.seg_flags[2]) begin
                mode_d = ST_CLOSED;
                plan.ack_v = 1'b0;
              end
              if (plan.ack_v) begin
                aseq_d = exp_d;
                aflg_d = F_ACK;
              end
              exp_d = exp_d + 32'd1;
            end else if (in_q.seg_flags == F_NONE) begin
              plan.ack_v = 1'b1;
            end
          end
          plan.ack_seq   = aseq_d;
          plan.ack_flags = aflg_d;

          if (mode_d == ST_CLOSED) begin
            rrun_d = 1'b0; rcnt_d = '0;
            crun_d = 1'b0; ccnt_d = '0;
          end
        end

        plan.state  = mode_d;
        plan_push_o = 1'b1;
        if (plan.rt_v) begin
          burst_d = 1'b1;
        end
      end
      default: fstate_d = FS_ACC;
    endcase
  end

  assign plan_o = plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fstate_q    <= FS_ACC;
      retx_lim_q  <= RETX_TICKS_RST;
      twait_lim_q <= TWAIT_TICKS_RST;
      mode_q      <= ST_IDLE;
      next_q      <= 32'd1;
      base_q      <= 32'd1;
      exp_q       <= 32'd1;
      nslot_q     <= SW'(1);
      bslot_q     <= SW'(1);
      head_q      <= '0;
      qcnt_q      <= '0;
      rrun_q      <= 1'b0;
      rcnt_q      <= '0;
      crun_q      <= 1'b0;
      ccnt_q      <= '0;
      aseq_q      <= '0;
      aflg_q      <= F_ACK;
      burst_q     <= 1'b0;
    end else begin
      fstate_q <= fstate_d;
      if (cfg_we_i && cfg_idx_i == CFG_RETX) begin
        retx_lim_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_TWAIT) begin
        twait_lim_q <= cfg_data_i;
      end
      mode_q  <= mode_d;
      next_q  <= next_d;
      base_q  <= base_d;
      exp_q   <= exp_d;
      nslot_q <= nslot_d;
      bslot_q <= bslot_d;
      head_q  <= head_d;
      qcnt_q  <= qcnt_d;
      rrun_q  <= rrun_d;
      rcnt_q  <= rcnt_d;
      crun_q  <= crun_d;
      ccnt_q  <= ccnt_d;
      aseq_q  <= aseq_d;
      aflg_q  <= aflg_d;
      burst_q <= burst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> fstate_q == FS_EXEC)
    else $error("accepted transaction not executed next cycle");
  a_plan_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstate_q == FS_EXEC |-> plan_room_i)
    else $error("plan queue full while a plan is pushed");
  a_burst_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !in_ready_o)
    else $error("input taken while a retransmit burst is pending");
  a_qcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QCW'(SEND_QUEUE_DEPTH))
    else $error("send queue count beyond depth");
`endif

endmodule

@@ src/gbn_back.sv @@
// gbn_back: expands plans into result transactions, reading the window
// memory for retransmit bursts; depends on gbn_pkg
`timescale 1ns / 1ps

module gbn_back import gbn_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      plan_valid_i,
  input  plan_t                     plan_i,
  output logic                      plan_pop_o,
  output logic                      win_re_o,
  output logic [$clog2(WINDOW)-1:0] win_raddr_o,
  input  win_entry_t                win_rdata_i,
  output logic                      rt_done_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output out_item_t                 out_data_o
);

  localparam int unsigned SW = $clog2(WINDOW);

  typedef enum logic [3:0] {
    BS_IDLE = 4'b0001,
    BS_RUN  = 4'b0010,
    BS_RTRD = 4'b0100,
    BS_RTEM = 4'b1000
  } back_state_e;

  typedef struct packed {
    logic st;
    logic nw;
    logic rt;
    logic rep;
    logic del;
    logic ack;
  } pend_t;

  back_state_e bstate_q, bstate_d;
  plan_t       cur_q, cur_d;
  pend_t       pend_q, pend_d;
  logic [CNT_MAX_W-1:0] idx_q, idx_d;
  logic [SW-1:0] slot_q, slot_d;
  logic        out_v_q, out_v_d;
  out_item_t   out_q, out_d;
  logic        free, burst_end;

  assign free = !out_v_q || out_ready_i;
  assign burst_end = idx_q == cur_q.rt_cnt - 1'b1;

  always_comb begin
    bstate_d   = bstate_q;
    cur_d      = cur_q;
    pend_d     = pend_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_d      = out_q;
    plan_pop_o = 1'b0;
    win_re_o   = 1'b0;
    win_raddr_o = slot_q;
    rt_done_o  = 1'b0;

    case (bstate_q)
      BS_IDLE: begin
        if (plan_valid_i) begin
          plan_pop_o = 1'b1;
          cur_d  = plan_i;
          pend_d = '{st: !(plan_i.new_v || plan_i.rt_v || plan_i.rep_v ||
                           plan_i.del_v || plan_i.ack_v),
                     nw: plan_i.new_v, rt: plan_i.rt_v, rep: plan_i.rep_v,
                     del: plan_i.del_v, ack: plan_i.ack_v};
          idx_d  = '0;
          slot_d = SW'(plan_i.rt_slot);
          bstate_d = BS_RUN;
        end
      end
      BS_RUN: begin
        if (pend_q.rt && !pend_q.nw) begin
          win_re_o = 1'b1;
          bstate_d = BS_RTRD;
        end else if (free) begin
          out_v_d = 1'b1;
          out_d   = '0;
          out_d.conn_state = cur_q.state;
          out_d.queue_full = cur_q.full;
          if (pend_q.nw) begin
            out_d.out_kind    = KIND_TX;
            out_d.tx_seq      = cur_q.new_seq;
            out_d.tx_flags    = cur_q.new_flags;
            out_d.out_handle  = cur_q.new_handle;
            out_d.has_payload = cur_q.new_pl;
            out_d.last = !(pend_q.rt || pend_q.rep || pend_q.del || pend_q.ack);
            pend_d.nw = 1'b0;
          end else if (pend_q.rep) begin
            out_d.out_kind = KIND_TX;
            out_d.tx_seq   = cur_q.rep_seq;
            out_d.tx_flags = F_ACK | F_SYN;
            out_d.last     = !(pend_q.del || pend_q.ack);
            pend_d.rep = 1'b0;
          end else if (pend_q.del) begin
            out_d.out_kind   = KIND_DELIVER;
            out_d.out_handle = cur_q.del_handle;
            out_d.last       = !pend_q.ack;
            pend_d.del = 1'b0;
          end else if (pend_q.ack) begin
            out_d.out_kind = KIND_TX;
            out_d.tx_seq   = cur_q.ack_seq;
            out_d.tx_flags = cur_q.ack_flags;
            out_d.last     = 1'b1;
            pend_d.ack = 1'b0;
          end else begin
            // status only
            out_d.last = 1'b1;
            pend_d.st  = 1'b0;
          end
          if (pend_d == '0) begin
            bstate_d = BS_IDLE;
          end
        end
      end
      BS_RTRD: begin
        bstate_d = BS_RTEM;
      end
      BS_RTEM: begin
        if (free) begin
          out_v_d = 1'b1;
          out_d   = '0;
          out_d.out_kind    = KIND_TX;
          out_d.tx_seq      = cur_q.rt_base + 32'(idx_q);
          out_d.tx_flags    = win_rdata_i.flags;
          out_d.out_handle  = win_rdata_i.handle;
          out_d.has_payload = win_rdata_i.pl;
          out_d.conn_state  = cur_q.state;
          out_d.queue_full  = cur_q.full;
          out_d.last = burst_end && !(pend_q.rep || pend_q.del || pend_q.ack);
          idx_d  = idx_q + 1'b1;
          slot_d = (slot_q == SW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
          bstate_d = BS_RUN;
          if (burst_end) begin
            pend_d.rt = 1'b0;
            rt_done_o = 1'b1;
            if (!(pend_q.rep || pend_q.del || pend_q.ack)) begin
              bstate_d = BS_IDLE;
            end
          end
        end
      end
      default: bstate_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bstate_q <= BS_IDLE;
      pend_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      bstate_q <= bstate_d;
      pend_q   <= pend_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    slot_q <= slot_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_done_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_done_o |-> bstate_q == BS_RTEM)
    else $error("burst done outside retransmit emit");
`endif

endmodule

@@ sim/gbn_engine_checker.sv @@
// gbn_engine_checker: watches the input, result and configuration ports of the
// go-back-n connection engine, predicts every result and compares; needs gbn_pkg
`timescale 1ns / 1ps

module gbn_engine_checker import gbn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          items_seen_o,
  output int          results_seen_o,
  output logic [3:0]  hint_mode_o,
  output logic [31:0] hint_base_o,
  output logic [31:0] hint_next_o,
  output logic [31:0] hint_exp_o
);

  localparam int unsigned WIN = WINDOW_DEF;
  localparam int unsigned QDEPTH = SEND_QUEUE_DEPTH_DEF;

  logic [31:0] retx_lim, twait_lim;
  logic [3:0]  mode;
  logic [31:0] nxt, base, expd;
  win_entry_t  wstore [WIN];
  logic [7:0]  squeue [QDEPTH];
  int unsigned qhead, qcount;
  logic        retx_run, close_run;
  logic [31:0] retx_cnt, close_cnt, ack_seq;
  logic [2:0]  ack_flags;

  out_item_t pass_q[$];
  out_item_t results_due[$];

  function automatic bit expired(logic run, logic [31:0] cnt, logic [31:0] lim);
    return run && (cnt >= ((lim == 32'd0) ? 32'd1 : lim));
  endfunction

  function automatic void start_conn();
    nxt = 32'd1;
    base = 32'd1;
    expd = 32'd1;
    qhead = 0;
    qcount = 0;
    retx_run = 1'b0;
    retx_cnt = '0;
    close_run = 1'b0;
    close_cnt = '0;
    ack_seq = '0;
    ack_flags = F_ACK;
  endfunction

  function automatic void push_seg(logic [1:0] kind, logic [31:0] seq, logic [2:0] flags,
                                   logic [7:0] handle, logic pl);
    out_item_t r;
    r = '0;
    r.out_kind = kind;
    r.tx_seq = seq;
    r.tx_flags = flags;
    r.out_handle = handle;
    r.has_payload = pl;
    pass_q.push_back(r);
  endfunction

  function automatic void resend(logic [31:0] seq);
    win_entry_t e;
    e = wstore[seq % WIN];
    push_seg(KIND_TX, seq, e.flags, e.handle, e.pl);
  endfunction

  function automatic void sender_step(logic hs, logic [2:0] flags);
    logic want, send, pl;
    logic [2:0] f;
    logic [7:0] h;
    if (mode == ST_TIME_WAIT) begin
      if (expired(close_run, close_cnt, twait_lim)) begin
        mode = ST_CLOSED;
        close_run = 1'b0;
      end
      return;
    end
    if ((nxt - base) >= WIN) return;
    want = qcount > 0 || mode inside {ST_SYN_SEND, ST_SYN_SENT, ST_FIN_SEND,
                                      ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_CLOSE_WAIT};
    if (!want) return;
    send = 1'b0;
    f = F_NONE;
    h = '0;
    pl = 1'b0;
    case (mode)
      ST_SYN_SEND: begin
        f = F_SYN; send = 1'b1; mode = ST_SYN_SENT;
      end
      ST_SYN_SENT: begin
        if (hs && (flags & F_ACK) != 0 && (flags & F_SYN) != 0) begin
          f = F_ACK; send = 1'b1; mode = ST_ESTABLISHED;
        end
      end
      ST_ESTABLISHED: begin
        if (qcount > 0) begin
          h = squeue[qhead % QDEPTH];
          qhead = (qhead + 1) % QDEPTH;
          qcount--;
          pl = 1'b1; send = 1'b1;
        end
      end
      ST_FIN_SEND: begin
        f = F_FIN; send = 1'b1; mode = ST_FIN_WAIT_1;
      end
      ST_FIN_WAIT_1: begin
        if (hs && (flags & F_ACK) != 0) mode = ST_FIN_WAIT_2;
      end
      ST_FIN_WAIT_2: begin
        if (hs && (flags & F_FIN) != 0) begin
          f = F_ACK; send = 1'b1; mode = ST_TIME_WAIT;
          close_run = 1'b1; close_cnt = '0;
        end
      end
      ST_CLOSE_WAIT: begin
        f = F_FIN; send = 1'b1; mode = ST_LAST_ACK;
      end
      default: ;
    endcase
    if (send) begin
      wstore[nxt % WIN] = '{flags: f, pl: pl, handle: h};
      resend(nxt);
      if (base == nxt) begin
        retx_run = 1'b1; retx_cnt = '0;
      end
      nxt++;
    end
  endfunction

  function automatic void receiver_step(logic hs, logic [31:0] seq, logic [2:0] flags,
                                        logic [7:0] handle);
    logic ack_due;
    if (mode == ST_SYN_ACK) begin
      mode = ST_SYN_RCVD;
      ack_seq = expd;
      ack_flags = F_ACK | F_SYN;
      push_seg(KIND_TX, ack_seq, ack_flags, '0, 1'b0);
      expd++;
    end
    if (!hs || (flags & F_SYN) != 0 || mode == ST_CLOSE_WAIT) return;
    if (seq == expd) begin
      ack_due = 1'b1;
      if (mode == ST_SYN_RCVD && (flags & F_ACK) != 0) begin
        ack_due = 1'b0;
        mode = ST_ESTABLISHED;
      end else if (mode == ST_ESTABLISHED && flags == F_NONE) begin
        push_seg(KIND_DELIVER, '0, F_NONE, handle, 1'b0);
      end else if (mode == ST_ESTABLISHED && (flags & F_FIN) != 0) begin
        mode = ST_CLOSE_WAIT;
      end else if (mode == ST_LAST_ACK && (flags & F_ACK) != 0) begin
        mode = ST_CLOSED;
        ack_due = 1'b0;
      end
      if (ack_due) begin
        ack_seq = expd;
        ack_flags = F_ACK;
        push_seg(KIND_TX, ack_seq, ack_flags, '0, 1'b0);
      end
      expd++;
    end else if (flags == F_NONE) begin
      push_seg(KIND_TX, ack_seq, ack_flags, '0, 1'b0);
    end
  endfunction

  // one engine pass: timers tick, command applies, then sender, acks, timeout, receiver
  function automatic void engine_pass(in_item_t it);
    logic hs, full;
    logic [31:0] nb, outst;
    out_item_t r;
    hs = it.action == ACT_SEG && it.checksum_ok;
    full = 1'b0;
    pass_q.delete();
    if (retx_run && retx_cnt != 32'hffff_ffff) retx_cnt++;
    if (close_run && close_cnt != 32'hffff_ffff) close_cnt++;
    if (it.action == ACT_CONNECT || it.action == ACT_ACCEPT) begin
      if (mode == ST_IDLE || mode == ST_CLOSED) begin
        start_conn();
        mode = (it.action == ACT_CONNECT) ? ST_SYN_SEND : ST_SYN_ACK;
        retx_run = 1'b1;
        retx_cnt = '0;
      end
    end else if (it.action == ACT_PUSH) begin
      if (qcount < QDEPTH) begin
        squeue[(qhead + qcount) % QDEPTH] = it.payload_handle;
        qcount++;
      end else begin
        full = 1'b1;
      end
    end else if (it.action == ACT_CLOSE) begin
      if (mode == ST_ESTABLISHED) mode = ST_FIN_SEND;
    end
    if (mode != ST_IDLE && mode != ST_CLOSED) begin
      sender_step(hs, it.seg_flags);
      if (hs && (it.seg_flags & F_ACK) != 0) begin
        nb = it.seg_seq + 32'd1;
        if ((nb - base) <= (nxt - base)) begin
          base = nb;
          retx_run = (base != nxt);
          retx_cnt = '0;
        end
      end
      if (expired(retx_run, retx_cnt, retx_lim)) begin
        outst = nxt - base;
        retx_cnt = '0;
        if (outst > WIN) outst = WIN;
        for (int unsigned i = 0; i < outst; i++) resend(base + i);
      end
      receiver_step(hs, it.seg_seq, it.seg_flags, it.payload_handle);
      if (mode == ST_CLOSED) begin
        retx_run = 1'b0; retx_cnt = '0;
        close_run = 1'b0; close_cnt = '0;
      end
    end
    if (pass_q.size() == 0) push_seg(KIND_STATUS, '0, F_NONE, '0, 1'b0);
    foreach (pass_q[k]) begin
      r = pass_q[k];
      r.conn_state = mode;
      r.queue_full = full;
      r.last = (k == pass_q.size() - 1);
      results_due.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      retx_lim = RETX_TICKS_RST;
      twait_lim = TWAIT_TICKS_RST;
      mode = ST_IDLE;
      start_conn();
      results_due.delete();
      fail_count_o <= 0;
      items_seen_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TWAIT) twait_lim = cfg_data_i;
        else retx_lim = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        engine_pass(in_data_i);
        items_seen_o <= items_seen_o + 1;
      end
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (results_due.size() == 0) begin
          if (fail_count_o < 10)
            $display("mismatch: unexpected result %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = results_due.pop_front();
          if (out_data_i.out_kind !== e.out_kind || out_data_i.tx_seq !== e.tx_seq ||
              out_data_i.tx_flags !== e.tx_flags || out_data_i.out_handle !== e.out_handle ||
              out_data_i.has_payload !== e.has_payload ||
              out_data_i.conn_state !== e.conn_state ||
              out_data_i.queue_full !== e.queue_full || out_data_i.last !== e.last) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %p actual %p", e, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    // hints for the stimulus side, visible after this edge
    pending_o <= results_due.size();
    hint_mode_o <= mode;
    hint_base_o <= base;
    hint_next_o <= nxt;
    hint_exp_o <= expd;
  end

endmodule

@@ sim/go_back_n_connection_engine_tb.sv @@
// go_back_n_connection_engine_tb: stimulus and verdict for the go-back-n engine
// depends on gbn_pkg, go_back_n_connection_engine and gbn_engine_checker
`timescale 1ns / 1ps

module go_back_n_connection_engine_tb import gbn_pkg::*;;

  // action codes the block does not define, treated as a plain tick
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 300;
  localparam int PHASE_ITEMS = 75;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_RETX;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int          fail_count, pending, items_seen, results_seen;
  logic [3:0]  hint_mode;
  logic [31:0] hint_base, hint_next, hint_exp;

  // idle percentages per side, switched as the random part goes on
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req = 1'b0;
  int quiet = 0;

  always #1 clk = ~clk;

  go_back_n_connection_engine dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  gbn_engine_checker chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .items_seen_o  (items_seen),
    .results_seen_o(results_seen),
    .hint_mode_o   (hint_mode),
    .hint_base_o   (hint_base),
    .hint_next_o   (hint_next),
    .hint_exp_o    (hint_exp)
  );

  // build one item from its fields
  function automatic in_item_t mk(logic [2:0] act, logic [31:0] seq, logic [2:0] flags,
                                  logic ok, logic [7:0] handle);
    in_item_t t;
    t.action = act;
    t.seg_seq = seq;
    t.seg_flags = flags;
    t.checksum_ok = ok;
    t.payload_handle = handle;
    return t;
  endfunction

  // play the far end: mostly the segment the current state is waiting for,
  // with random content, plus some noise and broken segments
  function automatic in_item_t peer_item();
    in_item_t t;
    int r, s;
    logic [31:0] span;
    t = mk(ACT_TICK, $urandom, 3'($urandom_range(0, 7)), 1'b1, 8'($urandom));
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    span = hint_next - hint_base;
    if (hint_mode == ST_IDLE || hint_mode == ST_CLOSED) begin
      if (r < 45) t.action = ACT_CONNECT;
      else if (r < 88) t.action = ACT_ACCEPT;
      else if (r < 94) t.action = ACT_PUSH;
      else t.action = ACT_SEG;
    end else if (r < 7) begin
      // noise: anything at all, including the spare actions
      t.action = 3'($urandom_range(0, 7));
      t.checksum_ok = 1'($urandom);
    end else if (r < 12) begin
      // broken segment, failed checksum
      t.action = ACT_SEG;
      t.checksum_ok = 1'b0;
      t.seg_seq = hint_exp;
    end else begin
      case (hint_mode)
        ST_SYN_SENT: t = mk(ACT_SEG, hint_base, F_ACK | F_SYN, 1'b1, 8'($urandom));
        ST_SYN_RCVD: t = mk(ACT_SEG, hint_exp, F_ACK, 1'b1, 8'($urandom));
        ST_ESTABLISHED: begin
          if (s < 30) t.action = ACT_PUSH;
          else if (s < 60) t = mk(ACT_SEG, hint_exp, F_NONE, 1'b1, 8'($urandom));
          else if (s < 85)
            t = mk(ACT_SEG, hint_base - 32'd1 + $urandom_range(0, span), F_ACK, 1'b1, '0);
          else if (s < 91) t = mk(ACT_SEG, hint_exp + 32'd1, F_NONE, 1'b1, 8'($urandom));
          else if (s < 96) t.action = ACT_CLOSE;
          else t = mk(ACT_SEG, hint_exp, F_FIN, 1'b1, '0);
        end
        ST_FIN_WAIT_1: t = mk(ACT_SEG, hint_next - 32'd1, F_ACK, 1'b1, '0);
        ST_FIN_WAIT_2: t = mk(ACT_SEG, hint_exp, F_FIN, 1'b1, '0);
        ST_LAST_ACK: t = mk(ACT_SEG, hint_exp, F_ACK, 1'b1, '0);
        ST_CLOSE_WAIT: t.action = (s < 50) ? ACT_PUSH : ACT_TICK;
        ST_TIME_WAIT: t.action = (s < 80) ? ACT_TICK : ACT_CONNECT;
        default: t.action = ACT_TICK;
      endcase
    end
    return t;
  endfunction

  // offer one transaction and hold it until the engine takes it
  task automatic send_item(in_item_t t);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic set_timers(logic [31:0] retx, logic [31:0] twait);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_RETX;
    cfg_data <= retx;
    @(posedge clk);
    cfg_idx <= CFG_TWAIT;
    cfg_data <= twait;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_item_t t;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: queue overflow while idle, extreme handles
    for (int i = 0; i < 17; i++)
      send_item(mk(ACT_PUSH, '0, F_NONE, 1'b1, (i == 0) ? 8'h00 : 8'hff - 8'(i)));
    // ignored items in idle: spare actions, close, segment
    send_item(mk(ACT_SPARE_LO, 32'hffff_ffff, 3'b111, 1'b1, 8'hff));
    send_item(mk(ACT_SPARE_HI, '0, F_NONE, 1'b0, '0));
    send_item(mk(ACT_CLOSE, '0, F_NONE, 1'b1, '0));
    send_item(mk(ACT_SEG, 32'd1, F_NONE, 1'b1, 8'h5a));
    // open actively, complete the handshake, deliver, bad checksum, duplicate ack
    send_item(mk(ACT_CONNECT, '0, F_NONE, 1'b1, '0));
    send_item(mk(ACT_SEG, 32'd1, F_ACK | F_SYN, 1'b1, '0));
    send_item(mk(ACT_SEG, 32'd1, F_NONE, 1'b1, 8'hff));
    send_item(mk(ACT_SEG, 32'd2, F_NONE, 1'b0, 8'h11));
    send_item(mk(ACT_SEG, 32'hffff_ffff, F_NONE, 1'b1, 8'h22));

    // random part over several timer settings and idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_timers(32'd1, 32'd1);
        1: set_timers(32'd0, 32'd3);
        2: set_timers(32'hffff_ffff, 32'hffff_ffff);
        default: set_timers(32'd6, 32'd0);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        int n;
        n = ph * PHASE_ITEMS + i;
        if (n < RANDOM_ITEMS / 3) begin
          send_idle = 9; recv_idle = 51;
        end else if (n < 2 * RANDOM_ITEMS / 3) begin
          send_idle = 51; recv_idle = 9;
        end else begin
          send_idle = 0; recv_idle = 0;
        end
        // long hold-off on the result side so the engine backs up
        if (n == 2 * RANDOM_ITEMS / 3 + 5) hold_req = 1'b1;
        t = peer_item();
        send_item(t);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d input transactions and %0d result transactions", items_seen,
             results_seen);
    $display("four timer settings incl. zero and all-ones, with stalls on both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
